>>> sv/ppp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

  // Coefficient format: signed fixed point, always 32 bits wide
  localparam int COEF_W = 32;
  localparam int CFG_W  = 64;
  localparam int CFG_IW = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_ROW0_COEF01 = 3'd0,
    CFG_ROW0_COEF23 = 3'd1,
    CFG_ROW1_COEF01 = 3'd2,
    CFG_ROW1_COEF23 = 3'd3,
    CFG_ROW2_COEF01 = 3'd4,
    CFG_ROW2_COEF23 = 3'd5
  } cfg_idx_e;

  localparam int REG_COUNT = 6;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [3:0] crow_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] image_u;
    logic signed [31:0] image_v;
    logic               zero_depth;
    logic               saturated;
  } result_t;

  // Sign and zero-depth flags that ride along the divider stages
  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic zero;
  } dflag_t;

endpackage

`default_nettype wire

>>> sv/ppp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ppp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/ppp_dot.sv
`timescale 1ns / 1ps
`default_nettype none

module ppp_dot
  import ppp_pkg::*;
#(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int DW = COEF_W + ((CW > FB) ? CW : FB) + 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire point_t               pt_i,
  input  wire crow_t [2:0]          coef_i,
  output logic                      vld_o,
  output logic signed [DW-1:0]      dot_o [3]
);

  localparam int PW = COEF_W + CW;

  logic signed [CW-1:0] p [3];
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [DW-1:0] trn_q  [3];
  logic signed [DW-1:0] sa_q   [3];
  logic signed [DW-1:0] sb_q   [3];
  logic signed [DW-1:0] sum_q  [3];
  logic [2:0]           vld_q;

  // Take the low coordinate bits as signed values
  assign p[0] = pt_i.point_x[CW-1:0];
  assign p[1] = pt_i.point_y[CW-1:0];
  assign p[2] = pt_i.point_z[CW-1:0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Multiply, then add in pairs, then form the final sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= $signed(coef_i[r][k]) * p[k];
        end
        trn_q[r] <= DW'($signed(coef_i[r][3])) <<< FB;
        sa_q[r]  <= DW'(prod_q[r][0]) + DW'(prod_q[r][1]);
        sb_q[r]  <= DW'(prod_q[r][2]) + trn_q[r];
        sum_q[r] <= sa_q[r] + sb_q[r];
      end
    end
  end

  assign vld_o = vld_q[2];
  assign dot_o = sum_q;

endmodule

`default_nettype wire

>>> sv/ppp_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ppp_div_step
  import ppp_pkg::*;
#(
  parameter int RW = 120,
  parameter int DW = 66,
  parameter int QW = 33,
  parameter int SH = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [RW-1:0] rem_u_i,
  input  wire logic [RW-1:0] rem_v_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [QW-1:0] q_u_i,
  input  wire logic [QW-1:0] q_v_i,
  input  wire dflag_t        flg_i,
  output logic               vld_o,
  output logic [RW-1:0]      rem_u_o,
  output logic [RW-1:0]      rem_v_o,
  output logic [DW-1:0]      den_o,
  output logic [QW-1:0]      q_u_o,
  output logic [QW-1:0]      q_v_o,
  output dflag_t             flg_o
);

  logic [RW-1:0] dsh;
  logic          ge_u, ge_v;
  logic [RW-1:0] rem_u_d, rem_v_d;
  logic [QW-1:0] q_u_d, q_v_d;

  // Compare against the shifted divisor and subtract where it fits
  always_comb begin
    dsh     = RW'(den_i) << SH;
    ge_u    = rem_u_i >= dsh;
    ge_v    = rem_v_i >= dsh;
    rem_u_d = ge_u ? rem_u_i - dsh : rem_u_i;
    rem_v_d = ge_v ? rem_v_i - dsh : rem_v_i;
    q_u_d   = q_u_i;
    q_v_d   = q_v_i;
    q_u_d[SH] = ge_u;
    q_v_d[SH] = ge_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_u_o <= rem_u_d;
      rem_v_o <= rem_v_d;
      den_o   <= den_i;
      q_u_o   <= q_u_d;
      q_v_o   <= q_v_d;
      flg_o   <= flg_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/point_perspective_projection.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                        Handshake
// pt_i     in   point_x, point_y, point_z                      valid/ready
// res_o    out  image_u, image_v, zero_depth, saturated        valid/ready
// cfg      in   cfg_idx_i, cfg_data_i (64 bits)                cfg_we_i
//
// One point enters per cycle while the output is not stalled. Each result passes
// through three dot-product stages, one sign stage, one restoring-divider stage
// per quotient bit plus an overflow bit, and the output register. The divider
// chain sets the latency.
// Reset clears all valid bits and the matrix registers to zero.
// A stall at the output freezes the whole pipeline; nothing is lost.

module point_perspective_projection
  import ppp_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IW-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  ppp_stream_if.sink             pt_i,
  ppp_stream_if.source           res_o
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int DW = COEF_W + ((CW > FB) ? CW : FB) + 2;
  localparam int RW = DW + CW + FB;
  localparam int QW = CW + 1;
  localparam int NS = CW + 2;

  logic [CFG_W-1:0]     cfg_q [REG_COUNT];
  crow_t [2:0]          coef;
  logic                 en;
  logic                 dot_vld;
  logic signed [DW-1:0] dot [3];

  logic                 vld   [NS];
  logic [RW-1:0]        rem_u [NS];
  logic [RW-1:0]        rem_v [NS];
  logic [DW-1:0]        den   [NS];
  logic [QW-1:0]        q_u   [NS];
  logic [QW-1:0]        q_v   [NS];
  dflag_t               flg   [NS];

  logic                 out_vld_q;
  result_t              out_q;
  result_t              out_d;

  // Hold matrix registers; ignore writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && cfg_idx_i <= CFG_ROW2_COEF23) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = cfg_q[2*r][31:0];
      coef[r][1] = cfg_q[2*r][63:32];
      coef[r][2] = cfg_q[2*r+1][31:0];
      coef[r][3] = cfg_q[2*r+1][63:32];
    end
  end

  // Advance the whole pipeline unless the output is stalled
  assign en       = !out_vld_q || res_o.ready;
  assign pt_i.ready = en;

  ppp_dot #(.CW(CW), .FB(FB), .DW(DW)) u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pt_i.valid),
    .pt_i   (pt_i.payload),
    .coef_i (coef),
    .vld_o  (dot_vld),
    .dot_o  (dot)
  );

  // Take magnitudes and signs, scale numerators by the fraction bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= dot_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_u[0]     <= RW'(dot[0][DW-1] ? DW'(-dot[0]) : DW'(dot[0])) << FB;
      rem_v[0]     <= RW'(dot[1][DW-1] ? DW'(-dot[1]) : DW'(dot[1])) << FB;
      den[0]       <= dot[2][DW-1] ? DW'(-dot[2]) : DW'(dot[2]);
      q_u[0]       <= '0;
      q_v[0]       <= '0;
      flg[0].neg_u <= dot[0][DW-1] ^ dot[2][DW-1];
      flg[0].neg_v <= dot[1][DW-1] ^ dot[2][DW-1];
      flg[0].zero  <= dot[2] == '0;
    end
  end

  // One quotient bit per stage, overflow bit first
  for (genvar j = 0; j < NS - 1; j++) begin : g_div
    ppp_div_step #(.RW(RW), .DW(DW), .QW(QW), .SH(CW - j)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (vld[j]),
      .rem_u_i (rem_u[j]),
      .rem_v_i (rem_v[j]),
      .den_i   (den[j]),
      .q_u_i   (q_u[j]),
      .q_v_i   (q_v[j]),
      .flg_i   (flg[j]),
      .vld_o   (vld[j+1]),
      .rem_u_o (rem_u[j+1]),
      .rem_v_o (rem_v[j+1]),
      .den_o   (den[j+1]),
      .q_u_o   (q_u[j+1]),
      .q_v_o   (q_v[j+1]),
      .flg_o   (flg[j+1])
    );
  end

  // Apply sign, clamp to the coordinate range, force zero depth
  always_comb begin
    logic          nu, nv, su, sv;
    logic [QW-1:0] lim_u, lim_v, mu, mv;
    logic [CW-1:0] ru, rv;
    nu    = flg[NS-1].neg_u && (q_u[NS-1] != '0);
    nv    = flg[NS-1].neg_v && (q_v[NS-1] != '0);
    lim_u = (QW'(1) << (CW - 1)) - (nu ? QW'(0) : QW'(1));
    lim_v = (QW'(1) << (CW - 1)) - (nv ? QW'(0) : QW'(1));
    su    = q_u[NS-1] > lim_u;
    sv    = q_v[NS-1] > lim_v;
    mu    = su ? lim_u : q_u[NS-1];
    mv    = sv ? lim_v : q_v[NS-1];
    ru    = nu ? CW'(-mu) : CW'(mu);
    rv    = nv ? CW'(-mv) : CW'(mv);
    if (flg[NS-1].zero) begin
      out_d = '{image_u: '0, image_v: '0, zero_depth: 1'b1, saturated: 1'b0};
    end else begin
      out_d.image_u    = 32'($signed(ru));
      out_d.image_v    = 32'($signed(rv));
      out_d.zero_depth = 1'b0;
      out_d.saturated  = su || sv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  // Zero depth gives a clean all-zero result
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.zero_depth |->
      out_q.image_u == '0 && out_q.image_v == '0 && !out_q.saturated)
    else $error("zero depth result not cleared");

  // A clamped result sits on a range bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.saturated |->
      out_q.image_u == 32'($signed(CW'(1) << (CW - 1))) ||
      out_q.image_u == 32'($signed(~(CW'(1) << (CW - 1)))) ||
      out_q.image_v == 32'($signed(CW'(1) << (CW - 1))) ||
      out_q.image_v == 32'($signed(~(CW'(1) << (CW - 1)))))
    else $error("saturated result not at a bound");

  // A stalled output blocks new transfers and holds its data
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_o.ready |-> !pt_i.ready ##1 $stable(out_q))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire
